// File: design/tbdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbdc_pkg
// Shared types, codes and reset constants for the two-beam direction counter.
// ----------------------------------------------------------------------------
package tbdc_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned OCC_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  // Default counter width
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd800;
  localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd2000;

  // Input event kinds
  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_BEAM_A = 2'd1,
    ACT_BEAM_B = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  // Which beam opened the pending passage
  typedef enum logic [1:0] {
    BEAM_NONE = 2'd0,
    BEAM_A    = 2'd1,
    BEAM_B    = 2'd2
  } beam_t;

  // Result codes
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_ENTRY   = 3'd1,
    EV_EXIT    = 3'd2,
    EV_CLEAR   = 3'd3,
    EV_TIMEOUT = 3'd4,
    EV_IGNORED = 3'd5
  } event_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 1'd0,
    REG_WINDOW   = 1'd1
  } reg_idx_t;

endpackage

// File: design/two_beam_direction_counter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_beam_direction_counter_core
// Direction-sensing people counter fed by timestamped beam events.
// ----------------------------------------------------------------------------
// One event beat is accepted every clock cycle while the result side keeps
// up. An accepted event is held in the input register, and its result is
// loaded into the result register when that register is free or draining,
// so each event yields exactly one result beat from the result register.
// The per-event work is one set of 32-bit timestamp subtractions and compares
// against the debounce and window registers plus the saturating counter step,
// all in the single stage that sits between those two registers.
// Configuration writes are always accepted and should only be issued while
// no event is in flight.
// ----------------------------------------------------------------------------
module two_beam_direction_counter_core #(
  parameter int unsigned COUNT_BITS = tbdc_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Event input
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tbdc_pkg::TIME_W-1:0]    in_tdata,   // [31:0] now_ms
  input  logic [1:0]                     in_tuser,   // [1:0] action
  // Result output
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tbdc_pkg::OCC_W-1:0]     out_tdata,  // [15:0] occupancy
  output logic [5:0]                     out_tuser,  // [2:0] event_res, [4:3] pending,
                                                     // [5] occupied
  // Configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tbdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tbdc_pkg::CFG_W-1:0]     cfg_data
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration registers
  logic [tbdc_pkg::CFG_W-1:0] debounce_r;
  logic [tbdc_pkg::CFG_W-1:0] window_r;

  // Input stage
  logic                        s1_valid_r;
  logic [1:0]                  s1_action_r;
  logic [tbdc_pkg::TIME_W-1:0] s1_now_r;

  // Counter state
  logic [COUNT_BITS-1:0]       count_r, count_nxt;
  tbdc_pkg::beam_t             first_beam_r, first_beam_nxt;
  logic [tbdc_pkg::TIME_W-1:0] first_time_r, first_time_nxt;
  logic [tbdc_pkg::TIME_W-1:0] last_a_r, last_a_nxt;
  logic [tbdc_pkg::TIME_W-1:0] last_b_r, last_b_nxt;

  // Result stage
  logic                        out_valid_r;
  logic [tbdc_pkg::OCC_W-1:0]  out_occ_r;
  tbdc_pkg::event_t            out_ev_r, ev_nxt;
  tbdc_pkg::beam_t             out_pend_r;
  logic                        out_occd_r;

  logic advance;

  // Working values for the event in the input stage
  logic [tbdc_pkg::TIME_W-1:0] since_a, since_b, since_first, since_first_nxt;
  logic [tbdc_pkg::TIME_W-1:0] debounce_ext, window_ext;
  logic                        a_ok, b_ok, in_window;

  // Move the input stage on when the result register is free or draining
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_occ_r;
  assign out_tuser  = {out_occd_r, out_pend_r, out_ev_r};

  assign debounce_ext = {{(tbdc_pkg::TIME_W-tbdc_pkg::CFG_W){1'b0}}, debounce_r};
  assign window_ext   = {{(tbdc_pkg::TIME_W-tbdc_pkg::CFG_W){1'b0}}, window_r};
  assign since_a      = s1_now_r - last_a_r;
  assign since_b      = s1_now_r - last_b_r;
  assign since_first  = s1_now_r - first_time_r;
  assign a_ok         = since_a >= debounce_ext;
  assign b_ok         = since_b >= debounce_ext;
  assign in_window    = since_first <= window_ext;

  // Decide the event outcome and next state
  always_comb begin
    count_nxt      = count_r;
    first_beam_nxt = first_beam_r;
    first_time_nxt = first_time_r;
    last_a_nxt     = last_a_r;
    last_b_nxt     = last_b_r;
    ev_nxt         = tbdc_pkg::EV_NONE;
    case (tbdc_pkg::action_t'(s1_action_r))
      tbdc_pkg::ACT_BEAM_A: begin
        if (!a_ok) begin
          ev_nxt = tbdc_pkg::EV_IGNORED;
        end else begin
          last_a_nxt = s1_now_r;
          if (first_beam_r == tbdc_pkg::BEAM_B && in_window) begin
            // B then A: someone left
            if (count_r != '0) count_nxt = count_r - 1'b1;
            first_beam_nxt = tbdc_pkg::BEAM_NONE;
            first_time_nxt = '0;
            ev_nxt         = tbdc_pkg::EV_EXIT;
          end else begin
            first_beam_nxt = tbdc_pkg::BEAM_A;
            first_time_nxt = s1_now_r;
          end
        end
      end
      tbdc_pkg::ACT_BEAM_B: begin
        if (!b_ok) begin
          ev_nxt = tbdc_pkg::EV_IGNORED;
        end else begin
          last_b_nxt = s1_now_r;
          if (first_beam_r == tbdc_pkg::BEAM_A && in_window) begin
            // A then B: someone entered
            if (count_r != COUNT_MAX) count_nxt = count_r + 1'b1;
            first_beam_nxt = tbdc_pkg::BEAM_NONE;
            first_time_nxt = '0;
            ev_nxt         = tbdc_pkg::EV_ENTRY;
          end else begin
            first_beam_nxt = tbdc_pkg::BEAM_B;
            first_time_nxt = s1_now_r;
          end
        end
      end
      tbdc_pkg::ACT_CLEAR: begin
        count_nxt      = '0;
        first_beam_nxt = tbdc_pkg::BEAM_NONE;
        first_time_nxt = '0;
        ev_nxt         = tbdc_pkg::EV_CLEAR;
      end
      default: begin
        ev_nxt = tbdc_pkg::EV_NONE;
      end
    endcase

    // Drop a stale pending passage
    since_first_nxt = s1_now_r - first_time_nxt;
    if (first_beam_nxt != tbdc_pkg::BEAM_NONE && since_first_nxt > window_ext) begin
      first_beam_nxt = tbdc_pkg::BEAM_NONE;
      first_time_nxt = '0;
      ev_nxt         = tbdc_pkg::EV_TIMEOUT;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= tbdc_pkg::DEBOUNCE_RST;
      window_r   <= tbdc_pkg::WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (tbdc_pkg::reg_idx_t'(cfg_index))
        tbdc_pkg::REG_DEBOUNCE: debounce_r <= cfg_data;
        tbdc_pkg::REG_WINDOW:   window_r   <= cfg_data;
        default:                debounce_r <= debounce_r;
      endcase
    end
  end

  // Capture incoming beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_action_r <= in_tuser;
      s1_now_r    <= in_tdata;
    end
  end

  // Commit state and load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      first_beam_r <= tbdc_pkg::BEAM_NONE;
      first_time_r <= '0;
      last_a_r     <= '0;
      last_b_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (advance) begin
        count_r      <= count_nxt;
        first_beam_r <= first_beam_nxt;
        first_time_r <= first_time_nxt;
        last_a_r     <= last_a_nxt;
        last_b_r     <= last_b_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_occ_r  <= tbdc_pkg::OCC_W'(count_nxt);
      out_ev_r   <= ev_nxt;
      out_pend_r <= first_beam_nxt;
      out_occd_r <= (count_nxt != '0);
    end
  end

  // Checks
  a_done_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_ev_r == tbdc_pkg::EV_ENTRY || out_ev_r == tbdc_pkg::EV_EXIT ||
                    out_ev_r == tbdc_pkg::EV_CLEAR || out_ev_r == tbdc_pkg::EV_TIMEOUT)
    |-> out_pend_r == tbdc_pkg::BEAM_NONE)
    else $error("passage still pending after it ended");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    advance && ev_nxt == tbdc_pkg::EV_CLEAR |=> count_r == '0 && !out_occd_r)
    else $error("count not zero after clear");

  a_ignore_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (ev_nxt == tbdc_pkg::EV_IGNORED || ev_nxt == tbdc_pkg::EV_TIMEOUT)
    |=> count_r == $past(count_r))
    else $error("count moved on an ignored or timed-out event");

  a_pending_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
    first_beam_r == tbdc_pkg::BEAM_NONE |-> first_time_r == '0)
    else $error("stale start time without a pending passage");

endmodule

// File: tb/two_beam_direction_counter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_beam_direction_counter_core_tb
// Self-checking bench for the two-beam people counter.
// ----------------------------------------------------------------------------
// A stimulus process fills a queue of timestamped beam events phase by phase.
// A clocked driver offers them in random bursts, and a clocked receiver stalls
// the result stream on its own pattern. Each accepted event runs through a
// local copy of the counting rules, and every result beat is compared field
// by field with the oldest prediction. Phases cover a directed walk through
// the corner cases, random passages under several debounce and window
// settings (extremes and timestamp wrap included), and a short gapless run
// of back-to-back passages.
// ----------------------------------------------------------------------------
module two_beam_direction_counter_core_tb;

  localparam int CNT_W       = tbdc_pkg::COUNT_BITS_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    tbdc_pkg::action_t act;
    logic [31:0]       now_ms;
  } beam_event_t;

  typedef struct packed {
    logic [tbdc_pkg::OCC_W-1:0] occupancy;
    tbdc_pkg::event_t           res;
    tbdc_pkg::beam_t            pending;
    logic                       occupied;
  } passage_report_t;

  // DUT ports
  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [tbdc_pkg::TIME_W-1:0]    in_tdata   = '0;   // [31:0] now_ms
  logic [1:0]                     in_tuser   = '0;   // [1:0] action
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [tbdc_pkg::OCC_W-1:0]     out_tdata;         // [15:0] occupancy
  logic [5:0]                     out_tuser;  // [2:0] event_res, [4:3] pending, [5] occupied
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [tbdc_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [tbdc_pkg::CFG_W-1:0]     cfg_data   = '0;

  // Mirror of the counter state and its registers
  logic [CNT_W-1:0]           occ_count;
  tbdc_pkg::beam_t            open_beam;
  logic [31:0]                open_ms;
  logic [31:0]                seen_a_ms;
  logic [31:0]                seen_b_ms;
  logic [tbdc_pkg::CFG_W-1:0] debounce_reg = tbdc_pkg::DEBOUNCE_RST;
  logic [tbdc_pkg::CFG_W-1:0] window_reg   = tbdc_pkg::WINDOW_RST;

  // Queues and bookkeeping
  beam_event_t     event_q [$];
  passage_report_t report_q [$];
  beam_event_t     beat;
  passage_report_t want;
  int n_queued   = 0;
  int n_offered  = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int cycle_cnt  = 0;
  int peak_occ   = 0;
  int ev_seen [6];

  // Sender and receiver pacing
  int burst_left = 1;
  int gap_left   = 0;
  bit no_gaps    = 1'b0;
  int rx_mode    = 0;
  int rx_left    = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  // Generator view of time and settings
  logic [31:0]                gen_ms;
  logic [tbdc_pkg::CFG_W-1:0] gen_debounce;
  logic [tbdc_pkg::CFG_W-1:0] gen_window;

  two_beam_direction_counter_core #(
    .COUNT_BITS(CNT_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Apply one event to the mirrored state and return the result it reports
  function automatic passage_report_t count_passage(tbdc_pkg::action_t act,
                                                    logic [31:0] now_ms);
    passage_report_t  r;
    tbdc_pkg::event_t res;
    tbdc_pkg::beam_t  beam;
    tbdc_pkg::beam_t  other;
    logic [31:0]      since;
    logic [31:0]      occ_full;
    res = tbdc_pkg::EV_NONE;
    if (act == tbdc_pkg::ACT_BEAM_A || act == tbdc_pkg::ACT_BEAM_B) begin
      if (act == tbdc_pkg::ACT_BEAM_A) begin
        beam  = tbdc_pkg::BEAM_A;
        other = tbdc_pkg::BEAM_B;
        since = now_ms - seen_a_ms;
      end else begin
        beam  = tbdc_pkg::BEAM_B;
        other = tbdc_pkg::BEAM_A;
        since = now_ms - seen_b_ms;
      end
      if (since < {16'd0, debounce_reg}) begin
        res = tbdc_pkg::EV_IGNORED;
      end else begin
        if (beam == tbdc_pkg::BEAM_A) seen_a_ms = now_ms;
        else seen_b_ms = now_ms;
        since = now_ms - open_ms;
        if (open_beam == other && since <= {16'd0, window_reg}) begin
          // B closing an A-first passage is an entry, the reverse an exit
          if (beam == tbdc_pkg::BEAM_B) begin
            if (occ_count != '1) occ_count = occ_count + 1'b1;
            res = tbdc_pkg::EV_ENTRY;
          end else begin
            if (occ_count != '0) occ_count = occ_count - 1'b1;
            res = tbdc_pkg::EV_EXIT;
          end
          open_beam = tbdc_pkg::BEAM_NONE;
          open_ms   = '0;
        end else begin
          open_beam = beam;
          open_ms   = now_ms;
        end
      end
    end else if (act == tbdc_pkg::ACT_CLEAR) begin
      occ_count = '0;
      open_beam = tbdc_pkg::BEAM_NONE;
      open_ms   = '0;
      res       = tbdc_pkg::EV_CLEAR;
    end
    // Drop a stale passage; this wins over any other code
    since = now_ms - open_ms;
    if (open_beam != tbdc_pkg::BEAM_NONE && since > {16'd0, window_reg}) begin
      open_beam = tbdc_pkg::BEAM_NONE;
      open_ms   = '0;
      res       = tbdc_pkg::EV_TIMEOUT;
    end
    occ_full    = 32'(occ_count);
    r.occupancy = occ_full[tbdc_pkg::OCC_W-1:0];
    r.res       = res;
    r.pending   = open_beam;
    r.occupied  = (occ_count != '0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      if (n_errors < MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
      n_errors++;
    end
  endtask

  // Monitor: check result beats, mirror register writes, predict accepted events
  always @(posedge clk) begin
    cycle_cnt++;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (report_q.size() == 0) begin
          if (n_errors < MAX_REPORTS)
            $display("%0t ns: result beat with nothing expected, got tdata %h tuser %h",
                     $time, out_tdata, out_tuser);
          n_errors++;
        end else begin
          want = report_q.pop_front();
          check_field("occupancy", 32'(want.occupancy), 32'(out_tdata));
          check_field("event_res", 32'(want.res), 32'(out_tuser[2:0]));
          check_field("pending", 32'(want.pending), 32'(out_tuser[4:3]));
          check_field("occupied", 32'(want.occupied), 32'(out_tuser[5]));
          ev_seen[want.res]++;
          if (int'(want.occupancy) > peak_occ) peak_occ = int'(want.occupancy);
          n_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (tbdc_pkg::reg_idx_t'(cfg_index))
          tbdc_pkg::REG_DEBOUNCE: debounce_reg = cfg_data;
          tbdc_pkg::REG_WINDOW:   window_reg   = cfg_data;
          default:                window_reg   = window_reg;
        endcase
      end
      if (in_tvalid && in_tready) begin
        report_q.push_back(count_passage(tbdc_pkg::action_t'(in_tuser), in_tdata));
        n_accepted++;
      end
    end
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t ns: run timed out after %0d cycles", $time, cycle_cnt);
      $display("** two_beam_direction_counter_core: FAILED **");
      $finish;
    end
  end

  // Driver: offer queued events in bursts with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (n_accepted == n_offered) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (event_q.size() != 0) begin
        beat = event_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= beat.act;
        in_tdata  <= beat.now_ms;
        n_offered++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: one long hold-off, otherwise switch among stall patterns
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ((cycle_cnt % 4) != 3);
      endcase
    end
  end

  task automatic push_event(input tbdc_pkg::action_t act, input logic [31:0] at_ms);
    event_q.push_back('{act: act, now_ms: at_ms});
    n_queued++;
  endtask

  // Wait until every queued event is taken and every result has come back
  task automatic drain();
    while (n_accepted != n_queued || report_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input tbdc_pkg::reg_idx_t idx,
                           input logic [tbdc_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed passages with random timing, plus ticks, noise and clears
  task automatic queue_random_traffic(input int n_items);
    int                k;
    int                pick;
    int                ticks;
    logic [31:0]       span;
    tbdc_pkg::action_t first_act;
    tbdc_pkg::action_t second_act;
    k = 0;
    while (k < n_items) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 1) == 0) begin
        first_act  = tbdc_pkg::ACT_BEAM_A;
        second_act = tbdc_pkg::ACT_BEAM_B;
      end else begin
        first_act  = tbdc_pkg::ACT_BEAM_B;
        second_act = tbdc_pkg::ACT_BEAM_A;
      end
      case ($urandom_range(0, 9))
        0:       span = gen_window;
        1:       span = gen_window + 1;
        2:       span = gen_window + $urandom_range(2, 5000);
        default: span = $urandom_range(0, gen_window);
      endcase
      if (pick < 60) begin
        // passage: first beam clear of debounce, optional ticks, then other beam
        gen_ms = gen_ms + gen_debounce + $urandom_range(0, 300);
        push_event(first_act, gen_ms);
        ticks = $urandom_range(0, 2);
        for (int j = 0; j < ticks; j++)
          push_event(tbdc_pkg::ACT_TICK, gen_ms + $urandom_range(0, span));
        gen_ms = gen_ms + span;
        push_event(second_act, gen_ms);
        k += 2 + ticks;
      end else if (pick < 75) begin
        gen_ms = gen_ms + $urandom_range(0, 2 * gen_window + 2);
        push_event(tbdc_pkg::ACT_TICK, gen_ms);
        k++;
      end else if (pick < 88) begin
        gen_ms = gen_ms + $urandom_range(0, 2 * gen_debounce + 2);
        push_event(first_act, gen_ms);
        k++;
      end else if (pick < 94) begin
        gen_ms = gen_ms + $urandom_range(0, 500);
        push_event(tbdc_pkg::ACT_CLEAR, gen_ms);
        k++;
      end else if (pick < 97) begin
        // jump to an arbitrary timestamp, possibly backwards
        gen_ms = $urandom;
        push_event(tbdc_pkg::action_t'($urandom_range(0, 3)), gen_ms);
        k++;
      end else begin
        // same beam twice restarts the passage
        gen_ms = gen_ms + gen_debounce + $urandom_range(0, 300);
        push_event(first_act, gen_ms);
        gen_ms = gen_ms + gen_debounce + $urandom_range(0, gen_window);
        push_event(first_act, gen_ms);
        k += 2;
      end
    end
  endtask

  task automatic run_phase(input logic [tbdc_pkg::CFG_W-1:0] deb,
                           input logic [tbdc_pkg::CFG_W-1:0] win,
                           input logic [31:0] start_ms, input int n_items);
    write_reg(tbdc_pkg::REG_DEBOUNCE, deb);
    write_reg(tbdc_pkg::REG_WINDOW, win);
    gen_debounce = deb;
    gen_window   = win;
    gen_ms       = start_ms;
    queue_random_traffic(n_items);
    drain();
  endtask

  // Stimulus and end of run
  initial begin
    occ_count = '0;
    open_beam = tbdc_pkg::BEAM_NONE;
    open_ms   = '0;
    seen_a_ms = '0;
    seen_b_ms = '0;
    foreach (ev_seen[i]) ev_seen[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed walk under reset settings (debounce 800, window 2000)
    push_event(tbdc_pkg::ACT_BEAM_A, 32'd0);          // inside debounce after reset
    push_event(tbdc_pkg::ACT_TICK,   32'd500);
    push_event(tbdc_pkg::ACT_BEAM_A, 32'd1000);       // arm A
    push_event(tbdc_pkg::ACT_BEAM_B, 32'd1500);       // entry
    push_event(tbdc_pkg::ACT_BEAM_B, 32'd3000);       // arm B
    push_event(tbdc_pkg::ACT_BEAM_A, 32'd4000);       // exit
    push_event(tbdc_pkg::ACT_BEAM_B, 32'd6000);
    push_event(tbdc_pkg::ACT_BEAM_A, 32'd6500);       // exit with count already at zero
    push_event(tbdc_pkg::ACT_BEAM_A, 32'd8000);
    push_event(tbdc_pkg::ACT_BEAM_A, 32'd9000);       // same beam again restarts
    push_event(tbdc_pkg::ACT_BEAM_B, 32'd11000);      // exactly at the window edge
    push_event(tbdc_pkg::ACT_BEAM_A, 32'd12000);
    push_event(tbdc_pkg::ACT_BEAM_B, 32'd14001);      // one past the window: restart from B
    push_event(tbdc_pkg::ACT_TICK,   32'd16002);      // stale passage dropped
    push_event(tbdc_pkg::ACT_BEAM_A, 32'd16500);
    push_event(tbdc_pkg::ACT_TICK,   32'd18500);      // still inside the window
    push_event(tbdc_pkg::ACT_BEAM_B, 32'd18600);
    push_event(tbdc_pkg::ACT_BEAM_B, 32'd70000);
    push_event(tbdc_pkg::ACT_BEAM_A, 32'd72500);      // other beam too late
    push_event(tbdc_pkg::ACT_BEAM_B, 32'd70100);      // debounced, but the timeout wins
    push_event(tbdc_pkg::ACT_CLEAR,  32'd70200);
    push_event(tbdc_pkg::ACT_BEAM_B, 32'hFFFF_FF00);
    push_event(tbdc_pkg::ACT_BEAM_A, 32'h0000_0100);  // passage across timestamp wrap
    push_event(tbdc_pkg::ACT_BEAM_A, 32'hFFFF_FFFF);
    push_event(tbdc_pkg::ACT_BEAM_B, 32'h0000_0300);
    drain();

    // Random traffic under a spread of settings, extremes included
    run_phase(16'd800,   16'd2000,  32'h0010_0000, 255);
    run_phase(16'd0,     16'd0,     32'h0200_0000, 255);
    run_phase(16'd65535, 16'd65535, 32'hFFF0_0000, 255);
    run_phase(16'd0,     16'd65535, 32'h8000_0000, 255);
    run_phase(16'd65535, 16'd0,     32'h4000_0000, 255);
    run_phase(16'd50,    16'd300,   32'hFFFF_F000, 255);
    run_phase(tbdc_pkg::CFG_W'($urandom), tbdc_pkg::CFG_W'($urandom), $urandom, 255);

    // Back-to-back passages with no gaps, then step down and back, clear
    write_reg(tbdc_pkg::REG_DEBOUNCE, 16'd0);
    write_reg(tbdc_pkg::REG_WINDOW, 16'd65535);
    no_gaps = 1'b1;
    gen_ms  = 32'h0100_0000;
    push_event(tbdc_pkg::ACT_CLEAR, gen_ms);
    for (int i = 0; i < 8; i++) begin
      push_event(tbdc_pkg::ACT_BEAM_A, gen_ms);
      push_event(tbdc_pkg::ACT_BEAM_B, gen_ms);
      gen_ms = gen_ms + 1;
    end
    push_event(tbdc_pkg::ACT_BEAM_B, gen_ms);
    push_event(tbdc_pkg::ACT_BEAM_A, gen_ms);
    push_event(tbdc_pkg::ACT_BEAM_A, gen_ms + 1);
    push_event(tbdc_pkg::ACT_BEAM_B, gen_ms + 1);
    push_event(tbdc_pkg::ACT_CLEAR, gen_ms + 2);
    drain();
    no_gaps = 1'b0;
    repeat (10) @(negedge clk);

    $display("Checked %0d result beats over 8 register settings and a gapless passage run",
             n_checked);
    $display("  entries %0d, exits %0d, clears %0d, timeouts %0d, debounced %0d, peak %0d",
             ev_seen[tbdc_pkg::EV_ENTRY], ev_seen[tbdc_pkg::EV_EXIT],
             ev_seen[tbdc_pkg::EV_CLEAR], ev_seen[tbdc_pkg::EV_TIMEOUT],
             ev_seen[tbdc_pkg::EV_IGNORED], peak_occ);
    if (n_errors == 0) begin
      $display("** two_beam_direction_counter_core: PASSED **");
    end else begin
      $display("** two_beam_direction_counter_core: FAILED **");
    end
    $finish;
  end

endmodule
